// File: design/assert_macros.svh
// Assertion macros shared by the list RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PAL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PAL_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define PAL_ASSERT(lbl, clk, rst, prop, msg)
`define PAL_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

// File: design/pal_pkg.sv
// Shared types and constants for the positional list block.
// No dependencies; used by pal_ram, pal_ctrl and positional_array_list.
`default_nettype none
package pal_pkg;

   localparam int unsigned DATA_W = 32;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_LOCATE = 2'd2;

   typedef struct packed {
      logic rd;
      logic wr;
   } mem_en_type;

endpackage
`default_nettype wire

// File: design/positional_array_list.sv
// Bounded ordered list of signed 32-bit elements: insert, delete, locate.
// Depends on pal_pkg, pal_ram and pal_ctrl.
//
// The block holds up to CAPACITY elements in a single-port-read, single-port-
// write synchronous RAM with registered read data, plus the element count
// in a register. One request word is worked on at a time. Insert at position
// p with n elements held moves entries n-1 down to p-1 up by one, then writes
// the new value; when p is n + 1 it only writes the new value. Delete reads
// the victim at p-1, then moves entries p..n-1 down by one. Locate scans from
// entry 0 and stops on the first match. Rejected requests (bad position, full
// list, unused command code) and a locate on an empty list go straight to the
// result. The longest requests are bounded by the walk over the RAM at one
// entry per cycle, which does not stall; a result held back by rsp_ready
// stretches a request by the stall. Reads and writes of a walk always hit
// entries two apart, so no forwarding is needed. The element store needs no
// clearing after reset: only entries below the count are ever read. The
// result sits in an output register, so the next request word is taken while
// a finished result still waits on rsp_ready.
`default_nettype none
module positional_array_list #(
   parameter int unsigned CAPACITY = 64,
   localparam int unsigned AW = $clog2(CAPACITY),
   localparam int unsigned POS_W = $clog2(CAPACITY + 2),
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_cmd,
   input  wire logic [POS_W-1:0]                  req_position,
   input  wire logic signed [pal_pkg::DATA_W-1:0] req_value,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_ok,
   output logic signed [pal_pkg::DATA_W-1:0]      rsp_removed_value,
   output logic [CNT_W-1:0]                       rsp_found_position,
   output logic [CNT_W-1:0]                       rsp_list_length
);
   import pal_pkg::*;

   // sequencer to output register
   logic                     res_valid;
   logic                     res_ready;
   logic                     res_ok;
   logic signed [DATA_W-1:0] res_removed;
   logic [CNT_W-1:0]         res_found;
   logic [CNT_W-1:0]         res_length;

   // sequencer to element store
   mem_en_type               mem_en;
   logic [AW-1:0]            mem_rd_addr;
   logic [AW-1:0]            mem_wr_addr;
   logic signed [DATA_W-1:0] mem_wdata;
   logic signed [DATA_W-1:0] mem_rdata;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_ok_ff;
   logic signed [DATA_W-1:0] rsp_removed_ff;
   logic [CNT_W-1:0]         rsp_found_ff;
   logic [CNT_W-1:0]         rsp_length_ff;
   logic                     load;

   pal_ram #(
      .CAPACITY (CAPACITY),
      .AW       (AW)
   ) u_ram (
      .clock   (clock),
      .mem_en  (mem_en),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wdata   (mem_wdata),
      .rdata   (mem_rdata)
   );

   pal_ctrl #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .POS_W    (POS_W),
      .CNT_W    (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_cmd      (req_cmd),
      .req_position (req_position),
      .req_value    (req_value),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res_ok       (res_ok),
      .res_removed  (res_removed),
      .res_found    (res_found),
      .res_length   (res_length),
      .mem_en       (mem_en),
      .mem_rd_addr  (mem_rd_addr),
      .mem_wr_addr  (mem_wr_addr),
      .mem_wdata    (mem_wdata),
      .mem_rdata    (mem_rdata)
   );

   // take a new result whenever the output slot is empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_ready;
   assign load      = res_valid && res_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      // hold the payload until a new result is loaded
      if (load) begin
         rsp_ok_ff      <= res_ok;
         rsp_removed_ff <= res_removed;
         rsp_found_ff   <= res_found;
         rsp_length_ff  <= res_length;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_removed_value  = rsp_removed_ff;
   assign rsp_found_position = rsp_found_ff;
   assign rsp_list_length    = rsp_length_ff;

endmodule
`default_nettype wire

// File: design/pal_ram.sv
// Element store: one write port, one read port, registered read data.
// Depends on pal_pkg for the enable struct and data width.
`default_nettype none
module pal_ram #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned AW = $clog2(CAPACITY)
) (
   input  wire logic                          clock,
   input  wire pal_pkg::mem_en_type           mem_en,
   input  wire logic [AW-1:0]                 rd_addr,
   input  wire logic [AW-1:0]                 wr_addr,
   input  wire logic signed [pal_pkg::DATA_W-1:0] wdata,
   output logic signed [pal_pkg::DATA_W-1:0]  rdata
);
   import pal_pkg::*;

   logic signed [DATA_W-1:0] mem_ff [CAPACITY];
   logic signed [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_en.wr) begin
         mem_ff[wr_addr] <= wdata;
      end
      if (mem_en.rd) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: design/pal_ctrl.sv
// Request sequencer: checks a request, walks the element store one entry a
// cycle and builds the result. Depends on pal_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module pal_ctrl #(
   parameter int unsigned CAPACITY = 64,
   parameter int unsigned AW = $clog2(CAPACITY),
   parameter int unsigned POS_W = $clog2(CAPACITY + 2),
   parameter int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_cmd,
   input  wire logic [POS_W-1:0]                  req_position,
   input  wire logic signed [pal_pkg::DATA_W-1:0] req_value,
   output logic                                   res_valid,
   input  wire logic                              res_ready,
   output logic                                   res_ok,
   output logic signed [pal_pkg::DATA_W-1:0]      res_removed,
   output logic [CNT_W-1:0]                       res_found,
   output logic [CNT_W-1:0]                       res_length,
   output pal_pkg::mem_en_type                    mem_en,
   output logic [AW-1:0]                          mem_rd_addr,
   output logic [AW-1:0]                          mem_wr_addr,
   output logic signed [pal_pkg::DATA_W-1:0]      mem_wdata,
   input  wire logic signed [pal_pkg::DATA_W-1:0] mem_rdata
);
   import pal_pkg::*;

   localparam int unsigned CMP_W = CNT_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_FINISH = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [1:0]               cmd_ff, cmd_in;
   logic [AW-1:0]            base_ff, base_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [AW-1:0]            rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pa_ff, pa_in;
   logic                     ok_ff, ok_in;
   logic signed [DATA_W-1:0] removed_ff, removed_in;
   logic [CNT_W-1:0]         found_ff, found_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic [CMP_W-1:0]         pos_x;
   logic [CMP_W-1:0]         cnt_x;
   logic                     ins_ok;
   logic                     del_ok;
   logic [AW-1:0]            p_idx;
   logic [CNT_W-1:0]         count_next;

   assign pos_x  = CMP_W'(req_position);
   assign cnt_x  = CMP_W'(count_ff);
   assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1))
                   && (count_ff != CNT_W'(CAPACITY));
   assign del_ok = (pos_x != '0) && (pos_x <= cnt_x);
   assign p_idx  = AW'(pos_x - CMP_W'(1));

   always_comb begin
      count_next = count_ff;
      if (ok_ff && cmd_ff == CMD_INSERT) begin
         count_next = count_ff + CNT_W'(1);
      end else if (ok_ff && cmd_ff == CMD_DELETE) begin
         count_next = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      base_in     = base_ff;
      val_in      = val_ff;
      rd_addr_in  = rd_addr_ff;
      rem_in      = rem_ff;
      pend_in     = 1'b0;
      pa_in       = pa_ff;
      ok_in       = ok_ff;
      removed_in  = removed_ff;
      found_in    = found_ff;
      count_in    = count_ff;
      mem_en      = '0;
      mem_rd_addr = rd_addr_ff;
      mem_wr_addr = base_ff;
      mem_wdata   = val_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               val_in     = req_value;
               base_in    = p_idx;
               ok_in      = 1'b0;
               removed_in = '0;
               found_in   = '0;
               state_in   = ST_DONE;
               case (req_cmd)
                  CMD_INSERT: begin
                     if (ins_ok) begin
                        ok_in = 1'b1;
                        if (cnt_x >= pos_x) begin
                           // shift the tail up, highest entry first
                           rd_addr_in = AW'(cnt_x - CMP_W'(1));
                           rem_in     = CNT_W'(cnt_x - pos_x + CMP_W'(1));
                           state_in   = ST_WALK;
                        end else begin
                           state_in = ST_FINISH;
                        end
                     end
                  end
                  CMD_DELETE: begin
                     if (del_ok) begin
                        ok_in      = 1'b1;
                        rd_addr_in = p_idx;
                        rem_in     = CNT_W'(cnt_x - pos_x + CMP_W'(1));
                        state_in   = ST_WALK;
                     end
                  end
                  CMD_LOCATE: begin
                     rd_addr_in = '0;
                     rem_in     = count_ff;
                     if (count_ff != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // issue the next read while the previous one's data lands
            if (rem_ff != '0) begin
               mem_en.rd = 1'b1;
               rem_in    = rem_ff - CNT_W'(1);
               pend_in   = 1'b1;
               pa_in     = rd_addr_ff;
               if (cmd_ff == CMD_INSERT) begin
                  rd_addr_in = rd_addr_ff - AW'(1);
               end else begin
                  rd_addr_in = rd_addr_ff + AW'(1);
               end
            end
            if (pend_ff) begin
               case (cmd_ff)
                  CMD_INSERT: begin
                     mem_en.wr   = 1'b1;
                     mem_wr_addr = pa_ff + AW'(1);
                     mem_wdata   = mem_rdata;
                  end
                  CMD_DELETE: begin
                     if (pa_ff == base_ff) begin
                        removed_in = mem_rdata;
                     end else begin
                        mem_en.wr   = 1'b1;
                        mem_wr_addr = pa_ff - AW'(1);
                        mem_wdata   = mem_rdata;
                     end
                  end
                  CMD_LOCATE: begin
                     if (mem_rdata == val_ff) begin
                        ok_in    = 1'b1;
                        found_in = CNT_W'(pa_ff) + CNT_W'(1);
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
               if (rem_ff == '0 && state_in == ST_WALK) begin
                  state_in = (cmd_ff == CMD_INSERT) ? ST_FINISH : ST_DONE;
               end
            end
         end
         ST_FINISH: begin
            mem_en.wr   = 1'b1;
            mem_wr_addr = base_ff;
            mem_wdata   = val_ff;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (res_ready) begin
               count_in = count_next;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      cmd_ff     <= cmd_in;
      base_ff    <= base_in;
      val_ff     <= val_in;
      rd_addr_ff <= rd_addr_in;
      rem_ff     <= rem_in;
      pa_ff      <= pa_in;
      ok_ff      <= ok_in;
      removed_ff <= removed_in;
      found_ff   <= found_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign res_valid   = (state_ff == ST_DONE);
   assign res_ok      = ok_ff;
   assign res_removed = removed_ff;
   assign res_found   = found_ff;
   assign res_length  = count_next;

   `PAL_ASSERT(a_rw_apart, clock, reset, (mem_en.rd && mem_en.wr) |-> (mem_rd_addr != mem_wr_addr), "read and write hit the same entry")
   `PAL_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "element count above capacity")
   `PAL_NEVER(a_write_quiet, clock, reset, mem_en.wr && (state_ff == ST_IDLE || state_ff == ST_DONE), "store written outside a walk")
   `PAL_ASSERT(a_count_hold, clock, reset, (state_ff != ST_DONE) |=> $stable(count_ff), "count moved before the result was handed off")

endmodule
`default_nettype wire
